// File: design/ltp_pkg.sv
`timescale 1ns / 1ps
// ltp_pkg: field widths, output limits and the divider result type
// shared by the linear trend predictor files. No dependencies.
package ltp_pkg;

  localparam int SAMPLE_W = 16;        // sample_distance
  localparam int PRED_W   = 18;        // predicted_distance
  localparam int HELD_W   = 4;         // samples_held
  localparam int QUOT_W   = PRED_W - 1; // quotient magnitude bits before saturation
  localparam int MIN_FIT  = 2;         // fewest samples that define a line

  localparam logic signed [PRED_W-1:0] PRED_MAX = {1'b0, {(PRED_W-1){1'b1}}};
  localparam logic signed [PRED_W-1:0] PRED_MIN = {1'b1, {(PRED_W-1){1'b0}}};

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } ltp_div_res_t;

endpackage

// File: design/ltp_sample_if.sv
`timescale 1ns / 1ps
// ltp_sample_if: valid/ready channel carrying one distance sample per beat.
// Depends on ltp_pkg.
interface ltp_sample_if;
  logic                          valid;
  logic                          ready;
  logic [ltp_pkg::SAMPLE_W-1:0]  sample_distance;

  modport source (output valid, output sample_distance, input ready);
  modport sink   (input valid, input sample_distance, output ready);
endinterface

// File: design/ltp_result_if.sv
`timescale 1ns / 1ps
// ltp_result_if: valid/ready channel carrying one prediction per beat.
// Depends on ltp_pkg.
interface ltp_result_if;
  logic                               valid;
  logic                               ready;
  logic                               prediction_valid;
  logic signed [ltp_pkg::PRED_W-1:0]  predicted_distance;
  logic [ltp_pkg::HELD_W-1:0]         samples_held;

  modport source (output valid, output prediction_valid, output predicted_distance,
                  output samples_held, input ready);
  modport sink   (input valid, input prediction_valid, input predicted_distance,
                  input samples_held, output ready);
endinterface

// File: design/ltp_cell.sv
`timescale 1ns / 1ps
// ltp_cell: one window slot of the sample chain; takes its neighbor's
// sample when the chain shifts. Depends on ltp_pkg.
module ltp_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [ltp_pkg::SAMPLE_W-1:0] d,
  output logic [ltp_pkg::SAMPLE_W-1:0] q
);

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: design/ltp_div.sv
`timescale 1ns / 1ps
// ltp_div: restoring divider, one quotient bit per cycle. Caller guarantees
// the quotient fits in QUOT_W bits. Depends on ltp_pkg.
module ltp_div #(
  parameter int DEN_W = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [DEN_W+ltp_pkg::QUOT_W-1:0]       mag,
  input  logic [DEN_W-1:0]                       den,
  output ltp_pkg::ltp_div_res_t                  res
);

  localparam int QW     = ltp_pkg::QUOT_W;
  localparam int STEP_W = $clog2(QW);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [QW-1:0]     work;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [DEN_W:0]    trial;
  logic              qbit;

  assign trial = {rem, work[QW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // datapath: high part of the dividend preloads the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= mag[DEN_W+QW-1 -: DEN_W];
      work  <= mag[QW-1:0];
      den_r <= den;
    end else if (busy) begin
      rem  <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      work <= {work[QW-2:0], qbit};
    end
  end

  assign res.done = done;
  assign res.quot = work;

endmodule

// File: design/linear_trend_predictor_unit.sv
`timescale 1ns / 1ps
// linear_trend_predictor_unit: least-squares line over a sliding window of
// distance samples, extrapolated one step ahead. Uses ltp_pkg, ltp_sample_if,
// ltp_result_if, ltp_cell and ltp_div.
//
//   channel  | dir | payload                                         | beat
//   ---------+-----+-------------------------------------------------+---------------
//   sample   | in  | sample_distance u16 (1/16 cm)                    | one sample
//   result   | out | prediction_valid, predicted_distance s18, held u4 | one prediction
//
// Sequence: a sample beat starts the rotation walk through the cell chain,
//   then the MUL, NUM and CHK states and the 17-step serial divider, which
//   is skipped below MIN_FIT samples or when the quotient would saturate.
//   Result valid rises in the same cycle that sample ready returns; no new sample is taken while one is in work.
// Reset: rst clears the fill count, the sequencer and the output valid; the
//   window cells themselves are never cleared and only aged slots are read.
// Stalls: a finished prediction sits in the output register; the next sample
//   is still taken while it waits, and a second result waits in DONE.
module linear_trend_predictor_unit #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  ltp_sample_if.sink          sample,
  ltp_result_if.source        result
);

  localparam int SW     = ltp_pkg::SAMPLE_W;
  localparam int QW     = ltp_pkg::QUOT_W;
  localparam int PW     = ltp_pkg::PRED_W;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int SY_W   = SW + CNT_W;
  localparam int T_W    = SW + $clog2(WINDOW_DEPTH * (WINDOW_DEPTH - 1) / 2 + 1);
  localparam int DEN_W  = 2 * CNT_W;
  localparam int MAG_W  = DEN_W + QW;      // equals CNT_W + 1 + SY_W
  localparam int NUM_W  = MAG_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_NUM  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]        state;
  logic              accept;
  logic [CNT_W-1:0]  cnt;       // samples held, n
  logic [IDX_W-1:0]  age;       // age of the sample leaving the chain tail

  // ---------------------------------------------------------------------
  // Cell chain. tap[k] holds the sample pushed k beats ago. A new sample
  // enters at the head; during the walk the tail wraps to the head, so
  // after WINDOW_DEPTH shifts the chain is back in place.
  // ---------------------------------------------------------------------
  logic [SW-1:0] tap [WINDOW_DEPTH];
  logic          shift_en;
  logic [SW-1:0] head_d;

  assign accept   = sample.valid & sample.ready;
  assign shift_en = accept | (state == ST_WALK);
  assign head_d   = (state == ST_WALK) ? tap[WINDOW_DEPTH-1] : sample.sample_distance;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_chain
    if (g == 0) begin : g_head
      ltp_cell u_cell (.clk(clk), .shift(shift_en), .d(head_d), .q(tap[g]));
    end else begin : g_body
      ltp_cell u_cell (.clk(clk), .shift(shift_en), .d(tap[g-1]), .q(tap[g]));
    end
  end

  // ---------------------------------------------------------------------
  // Sums. With ages k (newest k = 0) the prediction at x = n is
  //   (2(n-1)*Sy - 3*T) / (n(n-1)/2),   T = sum k*y_k.
  // Ages leave the tail oldest first, so T builds up as a running sum of
  // the suffix sums Sy (no multiplier). Ages at or above n are unwritten
  // and masked out.
  // ---------------------------------------------------------------------
  logic [SY_W-1:0] sy;
  logic [SY_W-1:0] sy_next;
  logic [T_W-1:0]  t;
  logic [SW-1:0]   y_eff;

  assign y_eff   = (CNT_W'(age) < cnt) ? tap[WINDOW_DEPTH-1] : '0;
  assign sy_next = sy + SY_W'(y_eff);

  logic [CNT_W:0]   fac;        // 2(n-1)
  logic [DEN_W-1:0] nn1;        // n(n-1)
  logic [MAG_W-1:0] prod;
  logic [MAG_W-1:0] t3;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [MAG_W-1:0] mag;
  logic             neg;

  assign fac = {CNT_W'(cnt - 1'b1), 1'b0};
  assign nn1 = DEN_W'(cnt) * DEN_W'(cnt - 1'b1);
  assign num = {1'b0, prod} - {1'b0, t3};

  // divider
  logic                  div_start;
  ltp_pkg::ltp_div_res_t div_res;

  assign div_start = (state == ST_CHK) && !(cnt < CNT_W'(ltp_pkg::MIN_FIT))
                     && (mag[MAG_W-1 -: DEN_W] < den);

  ltp_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .den   (den),
    .res   (div_res)
  );

  logic signed [PW-1:0] q_ext;
  assign q_ext = $signed({1'b0, div_res.quot});

  // finished result, then the output register
  logic                 res_pvalid;
  logic signed [PW-1:0] res_pred;
  logic                 out_valid;
  logic                 out_pvalid;
  logic signed [PW-1:0] out_pred;
  logic [ltp_pkg::HELD_W-1:0] out_held;
  logic                 out_load;

  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      age       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cnt != CNT_W'(WINDOW_DEPTH)) begin
              cnt <= cnt + 1'b1;
            end
            age   <= IDX_W'(WINDOW_DEPTH - 1);
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          age <= age - 1'b1;
          if (age == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_NUM;
        ST_NUM: state <= ST_CHK;
        ST_CHK: state <= div_start ? ST_DIV : ST_DONE;
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sy <= '0;
      t  <= '0;
    end else if (state == ST_WALK) begin
      sy <= sy_next;
      if (age != '0) begin
        t <= t + T_W'(sy_next);
      end
    end
    if (state == ST_MUL) begin
      prod <= MAG_W'(fac) * MAG_W'(sy);
      t3   <= MAG_W'(t) + MAG_W'({t, 1'b0});
      den  <= nn1 >> 1;
    end
    if (state == ST_NUM) begin
      neg <= num[NUM_W-1];
      mag <= num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
    end
    if (state == ST_CHK) begin
      if (cnt < CNT_W'(ltp_pkg::MIN_FIT)) begin
        res_pvalid <= 1'b0;
        res_pred   <= '0;
      end else begin
        res_pvalid <= 1'b1;
        res_pred   <= neg ? ltp_pkg::PRED_MIN : ltp_pkg::PRED_MAX;  // kept if saturated
      end
    end
    if (state == ST_DIV && div_res.done) begin
      res_pred <= neg ? -q_ext : q_ext;
    end
    if (out_load) begin
      out_pvalid <= res_pvalid;
      out_pred   <= res_pred;
      out_held   <= ltp_pkg::HELD_W'(cnt);
    end
  end

  assign sample.ready              = (state == ST_IDLE);
  assign result.valid              = out_valid;
  assign result.prediction_valid   = out_pvalid;
  assign result.predicted_distance = out_pred;
  assign result.samples_held       = out_held;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_WALK) && (age == IDX_W'(WINDOW_DEPTH - 1)))
    else $error("walk did not start from the oldest slot");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pvalid) |-> out_pred == '0)
    else $error("prediction not zero while invalid");

endmodule
